[hw/rtl/hll_pkg.sv]
// Shared constants, types and command format for the sketch insert block.
package hll_pkg;

    // MurmurHash64A constants
    localparam logic [63:0] MUR_M    = 64'hc6a4a7935bd1e995;
    localparam logic [63:0] MUR_SEED = 64'h8445d61a4e774912;
    localparam int          MUR_R    = 47;

    // bucket count limits
    localparam int          LOG_BUCKETS_MAX_DEF = 14;
    localparam int          LOG_BUCKETS_MIN     = 4;
    localparam logic [3:0]  LOG_BUCKETS_RST     = 4'd12;
    localparam int          LG_W                = 5;   // holds up to 31
    localparam int          IDX_W               = 21;  // widest store index

    // stream widths
    localparam int IN_TDATA_W  = 128;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 104;

    // input item kinds
    typedef enum logic [1:0] {
        MODE_KEY   = 2'd0,
        MODE_HASH  = 2'd1,
        MODE_MERGE = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    // classified command handed from front to back
    typedef struct packed {
        logic              is_merge;
        logic              other_dense;
        logic              in_range;
        logic [63:0]       hash;
        logic [IDX_W-1:0]  idx;
        logic [6:0]        value;
    } t_cmd;

endpackage

[hw/rtl/hll_ram.sv]
// Generic single write port RAM with registered read.
module hll_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[hw/rtl/hll_mul.sv]
// Sequential 64-bit by MUR_M multiplier, low 64 bits, one 32x32 product per cycle.
module hll_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    output logic        o_done,
    output logic [63:0] o_p
);
    import hll_pkg::*;

    logic [63:0] r_a;
    logic [63:0] r_p;
    logic [1:0]  r_ph;
    logic        r_run;
    logic        r_done;
    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] prod;

    // operand select per phase: lo*lo, hi*lo, lo*hi
    always_comb begin
        case (r_ph)
            2'd0:    begin mul_x = r_a[31:0];  mul_y = MUR_M[31:0];  end
            2'd1:    begin mul_x = r_a[63:32]; mul_y = MUR_M[31:0];  end
            default: begin mul_x = r_a[31:0];  mul_y = MUR_M[63:32]; end
        endcase
        prod = 64'(mul_x) * 64'(mul_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_ph   <= 2'd0;
        end else begin
            r_done <= !i_start && r_run && (r_ph == 2'd2);
            if (i_start) begin
                r_a   <= i_a;
                r_run <= 1'b1;
                r_ph  <= 2'd0;
            end else if (r_run) begin
                if (r_ph == 2'd0) begin
                    r_p <= prod;
                end else begin
                    r_p <= r_p + {prod[31:0], 32'd0};
                end
                if (r_ph == 2'd2) begin
                    r_run <= 1'b0;
                end else begin
                    r_ph <= r_ph + 2'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;
endmodule

[hw/rtl/hll_front.sv]
// Front end: accepts items, runs the key hash, classifies into commands.
module hll_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_clear,
    input  logic                           i_hold,
    input  logic [hll_pkg::LG_W-1:0]       i_lg,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [hll_pkg::IN_TDATA_W-1:0] i_tdata,
    input  logic [hll_pkg::IN_TUSER_W-1:0] i_tuser,
    input  logic                           i_tlast,
    output logic                           o_push,
    output hll_pkg::t_cmd                  o_cmd,
    input  logic                           i_full
);
    import hll_pkg::*;

    typedef enum logic [8:0] {
        F_IDLE = 9'b000000001,
        F_SEED = 9'b000000010,
        F_BODY = 9'b000000100,
        F_K1   = 9'b000001000,
        F_K2   = 9'b000010000,
        F_H    = 9'b000100000,
        F_MIX  = 9'b001000000,
        F_F    = 9'b010000000,
        F_PUSH = 9'b100000000
    } t_fstate;

    t_fstate     r_state, n_state;
    logic [63:0] r_acc, n_acc;
    logic        r_skip, n_skip;
    logic [63:0] r_word;
    logic [3:0]  r_nb;
    logic        r_last;
    logic [63:0] r_res, n_res;
    logic        r_merge;
    logic [13:0] r_midx;
    logic [6:0]  r_mval;
    logic        r_odense;

    logic        mul_start;
    logic [63:0] mul_a;
    logic        mul_done;
    logic [63:0] mul_p;

    // input unpacking
    t_mode       in_mode;
    logic        in_first;
    logic [31:0] in_klen;
    logic        accept;

    logic [63:0] tail_mask;
    logic [63:0] w;
    logic [6:0]  lz;
    logic [6:0]  rank;
    logic [6:0]  cap;
    logic [63:0] idx64;

    assign in_mode  = t_mode'(i_tuser[1:0]);
    assign in_first = i_tuser[2];
    assign in_klen  = i_tdata[99:68];
    assign o_ready  = (r_state == F_IDLE) && !i_hold;
    assign accept   = i_valid && o_ready;

    hll_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    // byte mask for a short tail
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            tail_mask[8*b +: 8] = (4'(b) < r_nb) ? 8'hFF : 8'h00;
        end
    end

    // hash sequencer
    always_comb begin
        n_state   = r_state;
        n_acc     = r_acc;
        n_skip    = r_skip;
        n_res     = r_res;
        mul_start = 1'b0;
        mul_a     = r_acc;
        case (r_state)
            F_IDLE: begin
                if (accept) begin
                    case (in_mode)
                        MODE_KEY: begin
                            if (in_first) begin
                                n_skip    = (in_klen == 32'd0);
                                mul_start = 1'b1;
                                mul_a     = 64'(in_klen);
                                n_state   = F_SEED;
                            end else if (!r_skip) begin
                                n_state = F_BODY;
                            end
                        end
                        MODE_HASH: begin
                            n_res   = i_tdata[63:0];
                            n_state = F_PUSH;
                        end
                        MODE_MERGE: begin
                            n_res   = 64'd0;
                            n_state = F_PUSH;
                        end
                        default: ;
                    endcase
                end
            end
            F_SEED: begin
                if (mul_done) begin
                    n_acc   = MUR_SEED ^ mul_p;
                    n_state = r_skip ? F_IDLE : F_BODY;
                end
            end
            F_BODY: begin
                if (r_nb >= 4'd8) begin
                    mul_start = 1'b1;
                    mul_a     = r_word;
                    n_state   = F_K1;
                end else if (r_nb != 4'd0) begin
                    mul_start = 1'b1;
                    mul_a     = r_acc ^ (r_word & tail_mask);
                    n_state   = F_H;
                end else begin
                    n_state = F_MIX;
                end
            end
            F_K1: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_a     = mul_p ^ (mul_p >> MUR_R);
                    n_state   = F_K2;
                end
            end
            F_K2: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_a     = r_acc ^ mul_p;
                    n_state   = F_H;
                end
            end
            F_H: begin
                if (mul_done) begin
                    n_acc   = mul_p;
                    n_state = F_MIX;
                end
            end
            F_MIX: begin
                if (r_last) begin
                    mul_start = 1'b1;
                    mul_a     = r_acc ^ (r_acc >> MUR_R);
                    n_state   = F_F;
                end else begin
                    n_state = F_IDLE;
                end
            end
            F_F: begin
                if (mul_done) begin
                    n_res   = mul_p ^ (mul_p >> MUR_R);
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    // bucket index and rank from the hash
    always_comb begin
        w     = r_res << i_lg;
        idx64 = r_res >> (7'd64 - 7'(i_lg));
        lz    = 7'd64;
        for (int i = 0; i < 64; i++) begin
            if (w[i]) begin
                lz = 7'(63 - i);
            end
        end
        cap  = 7'd65 - 7'(i_lg);
        rank = ((lz + 7'd1) < cap) ? (lz + 7'd1) : cap;
    end

    // command build
    always_comb begin
        o_cmd.is_merge    = r_merge;
        o_cmd.other_dense = r_merge && r_odense;
        o_cmd.hash        = r_res;
        if (r_merge) begin
            o_cmd.in_range = ((32'(r_midx) >> i_lg) == 32'd0);
            o_cmd.idx      = IDX_W'(r_midx);
            o_cmd.value    = r_mval;
        end else begin
            o_cmd.in_range = 1'b1;
            o_cmd.idx      = idx64[IDX_W-1:0];
            o_cmd.value    = rank;
        end
    end
    assign o_push = (r_state == F_PUSH) && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_acc   <= 64'd0;
            r_skip  <= 1'b0;
        end else if (i_clear) begin
            r_state <= F_IDLE;
            r_acc   <= 64'd0;
            r_skip  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_acc   <= n_acc;
            r_skip  <= n_skip;
        end
    end

    // payload capture
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (accept) begin
            r_word   <= i_tdata[63:0];
            r_nb     <= i_tdata[67:64];
            r_last   <= i_tlast;
            r_merge  <= (in_mode == MODE_MERGE);
            r_midx   <= i_tdata[113:100];
            r_mval   <= i_tdata[120:114];
            r_odense <= i_tdata[121];
        end
    end
endmodule

[hw/rtl/hll_fifo.sv]
// Small command queue between front and back.
module hll_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hll_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output hll_pkg::t_cmd o_cmd,
    output logic          o_empty
);
    import hll_pkg::*;

    localparam int AW = $clog2(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // pointers wrap at DEPTH
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end
endmodule

[hw/rtl/hll_back.sv]
// Back end: bucket store read-compare-write, sparse counter, dense flag, result register.
module hll_back #(
    parameter int LOG_BUCKETS_MAX = hll_pkg::LOG_BUCKETS_MAX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_clear,
    input  logic [hll_pkg::LG_W-1:0]        i_lg,
    output logic                            o_busy,
    input  logic                            i_empty,
    input  hll_pkg::t_cmd                   i_cmd,
    output logic                            o_pop,
    output logic                            o_tvalid,
    input  logic                            i_tready,
    output logic [hll_pkg::OUT_TDATA_W-1:0] o_tdata
);
    import hll_pkg::*;

    localparam int AW    = LOG_BUCKETS_MAX;
    localparam int DEPTH = 1 << LOG_BUCKETS_MAX;
    localparam int CNT_W = LOG_BUCKETS_MAX - 2;

    typedef enum logic [2:0] {
        B_CLEAR = 3'b001,
        B_IDLE  = 3'b010,
        B_CMP   = 3'b100
    } t_bstate;

    t_bstate                r_state;
    logic [AW-1:0]          r_clr_addr;
    t_cmd                   r_cmd;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_dense;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [6:0]             ram_wdata;
    logic [6:0]             ram_rdata;

    logic                   fire;
    logic                   d0;
    logic                   do_offer;
    logic                   up;
    logic [CNT_W-1:0]       cnt1;
    logic [CNT_W-1:0]       thr;
    logic                   d1;
    logic [31:0]            cnt32;

    assign o_busy = (r_state == B_CLEAR);
    assign o_pop  = (r_state == B_IDLE) && !i_empty;
    assign fire   = (r_state == B_CMP) && (!r_out_valid || i_tready);

    hll_ram #(.WIDTH(7), .DEPTH(DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (o_pop),
        .i_raddr (i_cmd.idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // offer the candidate to the bucket
    always_comb begin
        d0       = r_dense || (r_cmd.is_merge && r_cmd.other_dense);
        do_offer = !r_cmd.is_merge || r_cmd.in_range;
        up       = do_offer && (ram_rdata < r_cmd.value);
        cnt1     = r_cnt + CNT_W'(up && !d0 && (ram_rdata == 7'd0));
        thr      = CNT_W'(1) << (i_lg - LG_W'(LOG_BUCKETS_MIN));
        d1       = d0 || (do_offer && (cnt1 > thr));
        cnt32    = 32'(cnt1);
    end

    // write port: clearing sweep or bucket raise
    always_comb begin
        if (r_state == B_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = 7'd0;
        end else begin
            ram_we    = fire && up;
            ram_waddr = r_cmd.idx[AW-1:0];
            ram_wdata = r_cmd.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr_addr  <= '0;
            r_cnt       <= '0;
            r_dense     <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_clear) begin
            r_state    <= B_CLEAR;
            r_clr_addr <= '0;
            r_cnt      <= '0;
            r_dense    <= 1'b0;
        end else begin
            // result register loads on fire, empties on a transfer
            r_out_valid <= fire || (r_out_valid && !i_tready);
            case (r_state)
                B_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(DEPTH - 1)) begin
                        r_state <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (o_pop) begin
                        r_cmd   <= i_cmd;
                        r_state <= B_CMP;
                    end
                end
                B_CMP: begin
                    if (fire) begin
                        r_cnt   <= d0 ? r_cnt : cnt1;
                        r_dense <= d1;
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    // result payload: hash, index, rank, raised, dense, count
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= {2'b00,
                      (d0 ? 15'(32'(r_cnt)) : cnt32[14:0]),
                      d1,
                      up,
                      r_cmd.value,
                      r_cmd.idx[13:0],
                      r_cmd.hash};
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out;

    // queue is only drained with the store ready
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == B_IDLE) && !i_clear)
        else $error("queue popped while store busy");

    // dense mode only falls on a sketch clear or a reset
    a_dense_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_dense) |-> ($past(i_clear) || $past(!i_rst_n)))
        else $error("dense flag dropped without clear");

    // counter frozen once dense
    a_cnt_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dense && !i_clear) |=> $stable(r_cnt))
        else $error("counter moved in dense mode");

    // a raised bucket always carries a nonzero value
    a_raise_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out[85]) |-> (r_out[84:78] != 7'd0))
        else $error("raise with zero value");
endmodule

[hw/rtl/hll_sketch_insert_core.sv]
// Top level of the HyperLogLog sketch insert block.
//
// Input stream (s_axis): one item per transfer. tuser carries the item kind
// (key chunk, precomputed hash, merge) and the first-chunk flag, tlast marks
// the last chunk of a key. Output stream (m_axis): one result per key, hash
// or merge item; intermediate chunks, empty keys and unused kinds give none.
// Configuration: i_cfg_we writes log_buckets and clears the whole sketch.
// Hashing: the key hash runs on one 32x32 multiplier; each 64-bit product
// takes three partial products and the handoff. A full chunk runs the two
// key mixing products and the hash product, a short tail only the hash
// product, an empty chunk none; a first chunk adds the seed product, a last
// chunk adds the finalization product and the push into the queue. The
// front takes no new item until it is done with the last one, push included,
// and the back pops no command until the last one is in the result register.
// Reset and every configuration write start a clearing sweep of the bucket
// store over all 2^LOG_BUCKETS_MAX buckets, during which no item is taken.
// When the receiver stalls the result register holds; the queue fills, then
// the front stops taking items.
module hll_sketch_insert_core #(
    parameter int LOG_BUCKETS_MAX = hll_pkg::LOG_BUCKETS_MAX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [3:0]                      i_cfg_wdata,   // log_buckets
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // data_word[63:0], chunk_bytes[67:64], key_length[99:68],
    // merge_index[113:100], merge_value[120:114], other_dense[121], zero pad
    input  logic [hll_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // mode[1:0], first_chunk[2]
    input  logic [hll_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    input  logic                            s_axis_tlast,  // last_chunk
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // hash_value[63:0], bucket_index[77:64], rank_value[84:78], raised[85],
    // dense[86], nonzero_count[101:87], zero pad
    output logic [hll_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import hll_pkg::*;

    logic [3:0]      r_lg_cfg;
    logic [LG_W-1:0] lg_eff;
    logic            back_busy;
    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    t_cmd            cmd_in;
    t_cmd            cmd_out;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lg_cfg <= LOG_BUCKETS_RST;
        end else if (i_cfg_we) begin
            r_lg_cfg <= i_cfg_wdata;
        end
    end

    // clamp to the supported range
    always_comb begin
        if (LG_W'(r_lg_cfg) < LG_W'(LOG_BUCKETS_MIN)) begin
            lg_eff = LG_W'(LOG_BUCKETS_MIN);
        end else if (LG_W'(r_lg_cfg) > LG_W'(LOG_BUCKETS_MAX)) begin
            lg_eff = LG_W'(LOG_BUCKETS_MAX);
        end else begin
            lg_eff = LG_W'(r_lg_cfg);
        end
    end

    hll_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (i_cfg_we),
        .i_hold  (back_busy),
        .i_lg    (lg_eff),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_tdata (s_axis_tdata),
        .i_tuser (s_axis_tuser),
        .i_tlast (s_axis_tlast),
        .o_push  (push),
        .o_cmd   (cmd_in),
        .i_full  (full)
    );

    hll_fifo #(.DEPTH(4)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (cmd_out),
        .o_empty (empty)
    );

    hll_back #(.LOG_BUCKETS_MAX(LOG_BUCKETS_MAX)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (i_cfg_we),
        .i_lg     (lg_eff),
        .o_busy   (back_busy),
        .i_empty  (empty),
        .i_cmd    (cmd_out),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata)
    );
endmodule

[tb/sv/hll_sketch_insert_core_tb.sv]
// Testbench for the sketch insert core: keyed, hashed and merged updates checked against a predictor.
`timescale 1ns / 1ps

module hll_sketch_insert_core_tb;
    import hll_pkg::*;

    // one input item as the stream carries it
    typedef struct {
        t_mode       mode;
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        first;
        logic        last;
        logic [31:0] klen;
        logic [13:0] midx;
        logic [6:0]  mval;
        logic        odense;
    } t_sketch_item;

    // one update report
    typedef struct {
        logic [63:0] hash;
        logic [13:0] idx;
        logic [6:0]  rank;
        logic        raised;
        logic        dense;
        logic [14:0] count;
    } t_update_report;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [3:0]             i_cfg_wdata = 4'd0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    hll_sketch_insert_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state
    logic [6:0]     bucket_vals [0:16383];
    logic [14:0]    nz_buckets;
    logic           store_dense;
    logic [63:0]    run_hash;
    logic           skipping_key;
    logic [3:0]     lg_reg;
    t_update_report pending_reports [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;

    function automatic int lg_eff();
        if (lg_reg < 4) return 4;
        if (lg_reg > 14) return 14;
        return lg_reg;
    endfunction

    task automatic clear_sketch();
        for (int i = 0; i < 16384; i++) bucket_vals[i] = 7'd0;
        nz_buckets   = '0;
        store_dense  = 1'b0;
        run_hash     = '0;
        skipping_key = 1'b0;
    endtask

    // queue one expected report at the tail
    task automatic expect_report(input t_update_report r);
        pending_reports.insert(pending_reports.size(), r);
    endtask

    // max-update of one bucket, with sparse counting and the dense switch
    task automatic offer_bucket(input int idx, input logic [6:0] v, output logic up);
        int k;
        k  = 1 << lg_eff();
        up = 1'b0;
        if (bucket_vals[idx] < v) begin
            if (!store_dense && bucket_vals[idx] == 0) nz_buckets++;
            bucket_vals[idx] = v;
            up = 1'b1;
        end
        if (!store_dense && nz_buckets > k / 16) store_dense = 1'b1;
    endtask

    task automatic hash_to_bucket(input logic [63:0] h);
        int             lg;
        int             rank;
        logic [63:0]    w;
        t_update_report r;
        lg   = lg_eff();
        w    = h << lg;
        rank = 1;
        while (rank < 65 - lg && !w[63]) begin
            rank++;
            w = w << 1;
        end
        r.hash = h;
        r.idx  = 14'(h >> (64 - lg));
        r.rank = 7'(rank);
        offer_bucket(r.idx, r.rank, r.raised);
        r.dense = store_dense;
        r.count = nz_buckets;
        expect_report(r);
    endtask

    // predict the report of one accepted item
    task automatic predict_item(input t_sketch_item it);
        logic [63:0]    h;
        logic [63:0]    kk;
        logic [63:0]    mask;
        t_update_report r;
        case (it.mode)
            MODE_KEY: begin
                if (it.first) begin
                    skipping_key = (it.klen == 0);
                    run_hash = MUR_SEED ^ ({32'd0, it.klen} * MUR_M);
                end
                if (!skipping_key) begin
                    h = run_hash;
                    if (it.nbytes >= 8) begin
                        kk = it.word * MUR_M;
                        kk = kk ^ (kk >> MUR_R);
                        kk = kk * MUR_M;
                        h  = (h ^ kk) * MUR_M;
                    end else if (it.nbytes > 0) begin
                        mask = (64'd1 << (8 * it.nbytes)) - 1;
                        h    = (h ^ (it.word & mask)) * MUR_M;
                    end
                    run_hash = h;
                    if (it.last) begin
                        h = h ^ (h >> MUR_R);
                        h = h * MUR_M;
                        h = h ^ (h >> MUR_R);
                        hash_to_bucket(h);
                    end
                end
            end
            MODE_HASH: hash_to_bucket(it.word);
            MODE_MERGE: begin
                if (it.odense) store_dense = 1'b1;
                r.raised = 1'b0;
                if (it.midx < (1 << lg_eff())) offer_bucket(it.midx, it.mval, r.raised);
                r.hash  = '0;
                r.idx   = it.midx;
                r.rank  = it.mval;
                r.dense = store_dense;
                r.count = nz_buckets;
                expect_report(r);
            end
            default: ;
        endcase
    endtask

    // drive one item, wait for its transfer, then predict
    task automatic send_item(input t_sketch_item it);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, it.odense, it.mval, it.midx, it.klen, it.nbytes, it.word};
        s_axis_tuser  <= {it.first, it.mode};
        s_axis_tlast  <= it.last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_item(it);
    endtask

    // receiver stalls
    always @(negedge i_clk) m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // compare each result transfer with the oldest expectation
    t_update_report got;
    t_update_report want;
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.hash   = m_axis_tdata[63:0];
            got.idx    = m_axis_tdata[77:64];
            got.rank   = m_axis_tdata[84:78];
            got.raised = m_axis_tdata[85];
            got.dense  = m_axis_tdata[86];
            got.count  = m_axis_tdata[101:87];
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result: hash %h", got.hash);
            end else begin
                want = pending_reports.pop_front();
                if (got.hash !== want.hash || got.idx !== want.idx || got.rank !== want.rank
                    || got.raised !== want.raised || got.dense !== want.dense
                    || got.count !== want.count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp h=%h i=%0d r=%0d up=%b d=%b n=%0d,",
                                 want.hash, want.idx, want.rank, want.raised, want.dense,
                                 want.count,
                                 " got h=%h i=%0d r=%0d up=%b d=%b n=%0d",
                                 got.hash, got.idx, got.rank, got.raised,
                                 got.dense, got.count);
                end
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic t_sketch_item noise_item(input t_mode m);
        t_sketch_item it;
        it.mode   = m;
        it.word   = rand64();
        it.nbytes = 4'($urandom());
        it.first  = 1'($urandom());
        it.last   = 1'($urandom());
        it.klen   = $urandom();
        it.midx   = 14'($urandom());
        it.mval   = 7'($urandom());
        it.odense = 1'($urandom_range(0, 19) == 0);
        return it;
    endfunction

    // send a whole key: full chunks then a tail chunk
    task automatic send_key(input int nch, input int lastb, input logic [31:0] klen);
        t_sketch_item it;
        for (int c = 0; c < nch; c++) begin
            it        = noise_item(MODE_KEY);
            it.first  = (c == 0);
            it.last   = (c == nch - 1);
            it.nbytes = (c == nch - 1) ? 4'(lastb) : 4'd8;
            if (c == 0) it.klen = klen;
            send_item(it);
        end
    endtask

    // register write only with nothing in flight
    task automatic write_log_buckets(input logic [3:0] lg);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (40) @(negedge i_clk);
        i_cfg_we      <= 1'b1;
        i_cfg_wdata   <= lg;
        @(negedge i_clk);
        i_cfg_we      <= 1'b0;
        lg_reg = lg;
        clear_sketch();
    endtask

    // hash and merge helpers for the directed part
    task automatic send_hash(input logic [63:0] h);
        t_sketch_item it;
        it      = noise_item(MODE_HASH);
        it.word = h;
        send_item(it);
    endtask

    task automatic send_merge(input logic [13:0] idx, input logic [6:0] v, input logic od);
        t_sketch_item it;
        it        = noise_item(MODE_MERGE);
        it.midx   = idx;
        it.mval   = v;
        it.odense = od;
        send_item(it);
    endtask

    // directed corners at the reset bucket count
    task automatic test_directed();
        t_sketch_item it;
        send_key(1, 8, 32'd8);
        send_key(1, 3, 32'd3);
        send_key(3, 1, 32'd17);
        send_key(2, 8, 32'hFFFF_FFFF);
        send_key(3, 5, 32'd0);          // empty key, chunks dropped
        it = noise_item(MODE_KEY);      // chunk with no first, ends a key
        it.first = 1'b0; it.last = 1'b1; it.nbytes = 4'd6;
        send_item(it);
        it = noise_item(MODE_KEY);      // zero-byte last chunk
        it.first = 1'b1; it.last = 1'b1; it.nbytes = 4'd0; it.klen = 32'd1;
        send_item(it);
        it = noise_item(MODE_KEY);      // oversize chunk byte count
        it.first = 1'b1; it.last = 1'b1; it.nbytes = 4'd15; it.klen = 32'd9;
        send_item(it);
        send_hash(64'd0);
        send_hash('1);
        send_hash(64'h0000_0000_0000_0001);
        send_hash(64'hFFF0_0000_0000_0000);
        send_merge(14'd0, 7'd127, 1'b0);
        send_merge(14'd4095, 7'd1, 1'b0);
        send_merge(14'd16383, 7'd5, 1'b0);   // beyond the bucket count
        send_merge(14'd100, 7'd0, 1'b0);
        send_item(noise_item(MODE_NONE));
        send_merge(14'd7, 7'd3, 1'b1);       // dense source forces dense
        send_hash(64'h1234_5678_9abc_def0);
    endtask

    // random items, mostly well-formed keys
    task automatic test_random(input logic [3:0] lg, input int n,
                               input int sidle, input int ridle);
        int           pick;
        int           nch;
        int           lastb;
        logic [31:0]  klen;
        t_sketch_item it;
        write_log_buckets(lg);
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                nch   = $urandom_range(1, 4);
                lastb = $urandom_range(1, 8);
                klen  = ($urandom_range(0, 9) == 0) ? ($urandom() | 32'd1)
                                                   : 32'(8 * (nch - 1) + lastb);
                send_key(nch, lastb, klen);
            end else if (pick < 75) begin
                it = noise_item(MODE_HASH);
                if ($urandom_range(0, 2) == 0) it.word = it.word >> $urandom_range(0, 63);
                send_item(it);
            end else if (pick < 92) begin
                it = noise_item(MODE_MERGE);
                if ($urandom_range(0, 3) != 0)
                    it.midx = 14'($urandom_range(0, (1 << lg_eff()) - 1));
                send_item(it);
            end else if (pick < 95) begin
                send_key($urandom_range(1, 3), $urandom_range(1, 8), 32'd0);
            end else begin
                send_item(noise_item(t_mode'($urandom_range(0, 3))));
            end
        end
    endtask

    initial begin
        lg_reg = LOG_BUCKETS_RST;
        clear_sketch();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 23;
        recv_idle_pct = 81;
        test_directed();
        test_random(4'd4, 140, 23, 81);
        test_random(4'd14, 140, 23, 81);
        test_random(4'd15, 140, 81, 23);
        test_random(4'd0, 140, 81, 23);
        test_random(4'd9, 140, 0, 0);
        test_random(4'd6, 140, 0, 0);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #40_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
